// ===== hw/rtl/gss_pkg.sv =====
// Shared constants, types and helper functions for the group-sum-then-sort block.
package gss_pkg;

  localparam int CAPACITY  = 32;
  localparam int KEY_BYTES = 19;
  localparam int KEY_SLOTS = 19;
  localparam int KEY_W     = 8 * KEY_SLOTS;
  localparam int KEY_A_W   = 64;
  localparam int KEY_B_W   = 64;
  localparam int KEY_C_W   = 24;
  localparam int TOT_W     = 32;
  localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SORT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic [KEY_W-1:0]        wr_key;
    logic signed [TOT_W-1:0] wr_total;
  } mem_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [TOT_W-1:0] total;
  } mem_rd_t;

  function automatic logic signed [TOT_W-1:0] sat_add(input logic signed [TOT_W-1:0] x,
                                                      input logic signed [TOT_W-1:0] y);
    logic signed [TOT_W:0] s;
    s = {x[TOT_W-1], x} + {y[TOT_W-1], y};
    if (s[TOT_W] != s[TOT_W-1]) begin
      sat_add = s[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
    end else begin
      sat_add = s[TOT_W-1:0];
    end
  endfunction

  // Order by total, then by entry index so equal totals keep arrival order.
  function automatic logic rank_lt(input logic signed [TOT_W-1:0] ta,
                                   input logic [ADDR_W-1:0]       ia,
                                   input logic signed [TOT_W-1:0] tb,
                                   input logic [ADDR_W-1:0]       ib);
    rank_lt = (ta < tb) || ((ta == tb) && (ia < ib));
  endfunction

endpackage

// ===== hw/rtl/group_sum_then_sort.sv =====
// Group-by-key saturating summation with an ascending sorted flush: top level.
//
// An add request searches the stored entries: it reads one stored key
// and total per cycle through the single read port of the entry memories, then updates
// in place, appends, or drops a new key when the table is full. Each result of a flush
// of n entries comes from a selection pass that reads all n totals through that same port.
// An empty flush emits no result. busy is high while a request is at work. Each result
// appears for one cycle with out_valid high; the receiver cannot stall, so it must take
// every strobe. Equal totals come out in order of first appearance of their names.
module group_sum_then_sort
  import gss_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_req_type,
  input  logic [KEY_A_W-1:0]        in_key_bytes_a,
  input  logic [KEY_B_W-1:0]        in_key_bytes_b,
  input  logic [KEY_C_W-1:0]        in_key_bytes_c,
  input  logic signed [TOT_W-1:0]   in_amount,
  output logic                      out_valid,
  output logic [KEY_A_W-1:0]        out_key_a,
  output logic [KEY_B_W-1:0]        out_key_b,
  output logic [KEY_C_W-1:0]        out_key_c,
  output logic signed [TOT_W-1:0]   out_total,
  output logic                      out_is_last,
  output logic                      out_overflowed
);

  logic [KEY_W-1:0] canon_key;
  mem_req_t         mem_req;
  mem_rd_t          mem_rd;

  gss_canon u_canon (
    .key_a (in_key_bytes_a),
    .key_b (in_key_bytes_b),
    .key_c (in_key_bytes_c),
    .key   (canon_key)
  );

  gss_store u_store (
    .clk (clk),
    .req (mem_req),
    .rd  (mem_rd)
  );

  gss_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .req_type       (in_req_type),
    .canon_key      (canon_key),
    .amount         (in_amount),
    .mem_req        (mem_req),
    .mem_rd         (mem_rd),
    .out_valid      (out_valid),
    .out_key_a      (out_key_a),
    .out_key_b      (out_key_b),
    .out_key_c      (out_key_c),
    .out_total      (out_total),
    .out_is_last    (out_is_last),
    .out_overflowed (out_overflowed)
  );

endmodule

// ===== hw/rtl/gss_canon.sv =====
// Key canonicalization: zero every byte after the first zero byte or past the key length.
module gss_canon
  import gss_pkg::*;
(
  input  logic [KEY_A_W-1:0] key_a,
  input  logic [KEY_B_W-1:0] key_b,
  input  logic [KEY_C_W-1:0] key_c,
  output logic [KEY_W-1:0]   key
);

  logic [KEY_W-1:0] raw;

  assign raw = {key_a, key_b, key_c};

  always_comb begin
    logic alive;
    alive = 1'b1;
    key   = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (i >= KEY_BYTES) begin
        alive = 1'b0;
      end
      if (alive) begin
        key[KEY_W-1-8*i -: 8] = raw[KEY_W-1-8*i -: 8];
      end
      if (raw[KEY_W-1-8*i -: 8] == 8'd0) begin
        alive = 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/gss_store.sv =====
// Key and total memories: one write port, one registered read port.
module gss_store
  import gss_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output mem_rd_t  rd
);

  logic [KEY_W-1:0]        key_mem   [CAPACITY];
  logic signed [TOT_W-1:0] total_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_addr]   <= req.wr_key;
      total_mem[req.wr_addr] <= req.wr_total;
    end
    rd.key   <= key_mem[req.rd_addr];
    rd.total <= total_mem[req.rd_addr];
  end

endmodule

// ===== hw/rtl/gss_ctrl.sv =====
// Sequencer: key search with saturating update, and selection sort over the stored totals.
module gss_ctrl
  import gss_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    req_type,
  input  logic [KEY_W-1:0]        canon_key,
  input  logic signed [TOT_W-1:0] amount,
  output mem_req_t                mem_req,
  input  mem_rd_t                 mem_rd,
  output logic                    out_valid,
  output logic [KEY_A_W-1:0]      out_key_a,
  output logic [KEY_B_W-1:0]      out_key_b,
  output logic [KEY_C_W-1:0]      out_key_c,
  output logic signed [TOT_W-1:0] out_total,
  output logic                    out_is_last,
  output logic                    out_overflowed
);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic signed [TOT_W-1:0] amt_r, amt_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [ADDR_W-1:0]       chk_idx_r, chk_idx_nxt;
  logic                    first_r, first_nxt;
  logic signed [TOT_W-1:0] prev_total_r, prev_total_nxt;
  logic [ADDR_W-1:0]       prev_idx_r, prev_idx_nxt;
  logic                    best_vld_r, best_vld_nxt;
  logic signed [TOT_W-1:0] best_total_r, best_total_nxt;
  logic [ADDR_W-1:0]       best_idx_r, best_idx_nxt;
  logic [CNT_W-1:0]        emitted_r, emitted_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]        out_key_r, out_key_nxt;
  logic signed [TOT_W-1:0] out_total_r, out_total_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_ovf_r, out_ovf_nxt;

  logic accept;
  logic more;
  logic key_hit;
  logic cand_ok;
  logic cand_better;
  logic last_emit;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign more      = (idx_r < cnt_r);
  assign key_hit   = chk_vld_r && (mem_rd.key == key_r);
  assign cand_ok   = first_r || rank_lt(prev_total_r, prev_idx_r, mem_rd.total, chk_idx_r);
  assign cand_better = !best_vld_r ||
                       rank_lt(mem_rd.total, chk_idx_r, best_total_r, best_idx_r);
  assign last_emit = (CNT_W'(emitted_r + CNT_W'(1)) == cnt_r);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    key_nxt        = key_r;
    amt_nxt        = amt_r;
    idx_nxt        = idx_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    first_nxt      = first_r;
    prev_total_nxt = prev_total_r;
    prev_idx_nxt   = prev_idx_r;
    best_vld_nxt   = best_vld_r;
    best_total_nxt = best_total_r;
    best_idx_nxt   = best_idx_r;
    emitted_nxt    = emitted_r;
    out_valid_nxt  = 1'b0;
    out_key_nxt    = out_key_r;
    out_total_nxt  = out_total_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;

    mem_req.rd_addr  = idx_r[ADDR_W-1:0];
    mem_req.wr_en    = 1'b0;
    mem_req.wr_addr  = chk_idx_r;
    mem_req.wr_key   = key_r;
    mem_req.wr_total = amt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt     = '0;
          chk_vld_nxt = 1'b0;
          if (req_type == REQ_ADD) begin
            key_nxt   = canon_key;
            amt_nxt   = amount;
            state_nxt = ST_SCAN;
          end else if (cnt_r == '0) begin
            ovf_nxt = 1'b0;
          end else begin
            first_nxt    = 1'b1;
            best_vld_nxt = 1'b0;
            emitted_nxt  = '0;
            state_nxt    = ST_SORT;
          end
        end
      end

      ST_SCAN: begin
        if (key_hit) begin
          // Update in place and stop the search.
          mem_req.wr_en    = 1'b1;
          mem_req.wr_total = sat_add(mem_rd.total, amt_r);
          state_nxt        = ST_IDLE;
        end else if (more) begin
          idx_nxt     = CNT_W'(idx_r + CNT_W'(1));
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r[ADDR_W-1:0];
        end else if (chk_vld_r) begin
          chk_vld_nxt = 1'b0;
        end else begin
          // No stored key matched: append or drop.
          if (cnt_r < CNT_W'(CAPACITY)) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cnt_r[ADDR_W-1:0];
            cnt_nxt         = CNT_W'(cnt_r + CNT_W'(1));
          end else begin
            ovf_nxt = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_SORT: begin
        if (chk_vld_r && cand_ok && cand_better) begin
          best_vld_nxt   = 1'b1;
          best_total_nxt = mem_rd.total;
          best_idx_nxt   = chk_idx_r;
        end
        if (more) begin
          idx_nxt     = CNT_W'(idx_r + CNT_W'(1));
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r[ADDR_W-1:0];
        end else if (chk_vld_r) begin
          chk_vld_nxt = 1'b0;
        end else begin
          // Pass complete: fetch the selected entry.
          mem_req.rd_addr = best_idx_r;
          state_nxt       = ST_EMIT;
        end
      end

      ST_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_key_nxt    = mem_rd.key;
        out_total_nxt  = mem_rd.total;
        out_last_nxt   = last_emit;
        out_ovf_nxt    = ovf_r;
        prev_total_nxt = best_total_r;
        prev_idx_nxt   = best_idx_r;
        first_nxt      = 1'b0;
        emitted_nxt    = CNT_W'(emitted_r + CNT_W'(1));
        idx_nxt        = '0;
        chk_vld_nxt    = 1'b0;
        best_vld_nxt   = 1'b0;
        if (last_emit) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SORT;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      best_vld_r  <= 1'b0;
      first_r     <= 1'b1;
      idx_r       <= '0;
      emitted_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      best_vld_r  <= best_vld_nxt;
      first_r     <= first_nxt;
      idx_r       <= idx_nxt;
      emitted_r   <= emitted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    amt_r        <= amt_nxt;
    chk_idx_r    <= chk_idx_nxt;
    prev_total_r <= prev_total_nxt;
    prev_idx_r   <= prev_idx_nxt;
    best_total_r <= best_total_nxt;
    best_idx_r   <= best_idx_nxt;
    out_key_r    <= out_key_nxt;
    out_total_r  <= out_total_nxt;
    out_last_r   <= out_last_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_key_a      = out_key_r[KEY_W-1 -: KEY_A_W];
  assign out_key_b      = out_key_r[KEY_W-KEY_A_W-1 -: KEY_B_W];
  assign out_key_c      = out_key_r[KEY_C_W-1:0];
  assign out_total      = out_total_r;
  assign out_is_last    = out_last_r;
  assign out_overflowed = out_ovf_r;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for group_sum_then_sort: directed and random record streams and flushes against a local tally.
module tb
  import gss_pkg::*;
();

  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 2 * (CAPACITY + 2) + 10;
  localparam int RANDOM_ITEMS = 500;
  localparam logic signed [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
  localparam logic signed [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

  typedef struct {
    logic                    kind;
    logic [KEY_A_W-1:0]      key_a;
    logic [KEY_B_W-1:0]      key_b;
    logic [KEY_C_W-1:0]      key_c;
    logic signed [TOT_W-1:0] amount;
    bit                      drain_first;
  } request_t;

  typedef struct {
    logic [KEY_A_W-1:0]      key_a;
    logic [KEY_B_W-1:0]      key_b;
    logic [KEY_C_W-1:0]      key_c;
    logic signed [TOT_W-1:0] total;
    logic                    is_last;
    logic                    overflowed;
  } row_t;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    start          = 1'b0;
  logic                    busy;
  logic                    in_req_type    = REQ_ADD;
  logic [KEY_A_W-1:0]      in_key_bytes_a = '0;
  logic [KEY_B_W-1:0]      in_key_bytes_b = '0;
  logic [KEY_C_W-1:0]      in_key_bytes_c = '0;
  logic signed [TOT_W-1:0] in_amount      = '0;
  logic                    out_valid;
  logic [KEY_A_W-1:0]      out_key_a;
  logic [KEY_B_W-1:0]      out_key_b;
  logic [KEY_C_W-1:0]      out_key_c;
  logic signed [TOT_W-1:0] out_total;
  logic                    out_is_last;
  logic                    out_overflowed;

  request_t                pending[$];
  request_t                live_request;
  row_t                    sorted_rows_due[$];
  logic [KEY_W-1:0]        tally_keys[CAPACITY];
  logic signed [TOT_W-1:0] tally_totals[CAPACITY];
  int                      tally_count   = 0;
  bit                      tally_dropped = 1'b0;
  int                      mismatches    = 0;
  int                      queued_items  = 0;
  int                      gap_left      = 0;
  int                      calm_left     = 0;
  int                      quiet_cycles  = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  group_sum_then_sort i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_key_bytes_a (in_key_bytes_a),
    .in_key_bytes_b (in_key_bytes_b),
    .in_key_bytes_c (in_key_bytes_c),
    .in_amount      (in_amount),
    .out_valid      (out_valid),
    .out_key_a      (out_key_a),
    .out_key_b      (out_key_b),
    .out_key_c      (out_key_c),
    .out_total      (out_total),
    .out_is_last    (out_is_last),
    .out_overflowed (out_overflowed)
  );

  task automatic log_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Apply one accepted request to the tally; a flush queues its rows in ascending order.
  function automatic void tally_request(input request_t r);
    logic [KEY_W-1:0] raw;
    logic [KEY_W-1:0] name;
    logic [7:0]       b;
    bit               ended;
    bit               found;
    longint           sum;
    int               order[CAPACITY];
    int               j;
    row_t             row;
    if (r.kind == REQ_ADD) begin
      raw   = {r.key_a, r.key_b, r.key_c};
      name  = '0;
      ended = 1'b0;
      // Zero every byte past the first zero byte.
      for (int i = 0; i < KEY_SLOTS; i++) begin
        b = raw[KEY_W-1-8*i -: 8];
        if (i >= KEY_BYTES || ended) b = 8'h00;
        if (b == 8'h00) ended = 1'b1;
        name[KEY_W-1-8*i -: 8] = b;
      end
      found = 1'b0;
      for (int i = 0; i < tally_count && !found; i++) begin
        if (tally_keys[i] == name) begin
          sum = longint'(tally_totals[i]) + longint'(r.amount);
          if (sum > longint'(TOT_MAX)) tally_totals[i] = TOT_MAX;
          else if (sum < longint'(TOT_MIN)) tally_totals[i] = TOT_MIN;
          else tally_totals[i] = TOT_W'(sum);
          found = 1'b1;
        end
      end
      if (!found) begin
        if (tally_count < CAPACITY) begin
          tally_keys[tally_count]   = name;
          tally_totals[tally_count] = r.amount;
          tally_count++;
        end else begin
          tally_dropped = 1'b1;
        end
      end
    end else begin
      // Stable insertion sort keeps equal totals in arrival order.
      for (int i = 0; i < tally_count; i++) begin
        j = i;
        while (j > 0 && tally_totals[order[j-1]] > tally_totals[i]) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = i;
      end
      for (int i = 0; i < tally_count; i++) begin
        row.key_a      = tally_keys[order[i]][KEY_W-1 -: KEY_A_W];
        row.key_b      = tally_keys[order[i]][KEY_B_W+KEY_C_W-1 -: KEY_B_W];
        row.key_c      = tally_keys[order[i]][KEY_C_W-1:0];
        row.total      = tally_totals[order[i]];
        row.is_last    = (i == tally_count - 1);
        row.overflowed = tally_dropped;
        sorted_rows_due.push_back(row);
      end
      tally_count   = 0;
      tally_dropped = 1'b0;
    end
  endfunction

  function automatic logic signed [TOT_W-1:0] pick_amount();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return TOT_W'(int'($urandom_range(0, 8)) - 4);
    if (r < 60) begin
      case ($urandom_range(0, 3))
        0:       return TOT_MAX;
        1:       return TOT_MIN;
        2:       return TOT_MAX - TOT_W'($urandom_range(0, 15));
        default: return TOT_MIN + TOT_W'($urandom_range(0, 15));
      endcase
    end
    return TOT_W'($urandom);
  endfunction

  // Canonical name: a run of nonzero bytes, zeros after it.
  function automatic logic [KEY_W-1:0] fresh_name();
    int               len;
    int               r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 30) len = KEY_BYTES;
    else len = $urandom_range(1, KEY_BYTES);
    k = '0;
    for (int i = 0; i < len; i++) k[KEY_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // Fill the bytes past the terminator with junk half the time.
  function automatic logic [KEY_W-1:0] name_with_tail(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    bit               ended;
    r     = k;
    ended = 1'b0;
    if ($urandom_range(0, 1) == 0) return r;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (ended) r[KEY_W-1-8*i -: 8] = 8'($urandom_range(0, 255));
      else if (r[KEY_W-1-8*i -: 8] == 8'h00) ended = 1'b1;
    end
    return r;
  endfunction

  function automatic void queue_add(input logic [KEY_W-1:0] k, input logic signed [TOT_W-1:0] amt);
    request_t r;
    r.kind        = REQ_ADD;
    r.key_a       = k[KEY_W-1 -: KEY_A_W];
    r.key_b       = k[KEY_B_W+KEY_C_W-1 -: KEY_B_W];
    r.key_c       = k[KEY_C_W-1:0];
    r.amount      = amt;
    r.drain_first = 1'b0;
    pending.push_back(r);
    queued_items++;
  endfunction

  function automatic void queue_flush(input bit drain);
    request_t r;
    r.kind        = REQ_FLUSH;
    r.key_a       = {$urandom, $urandom};
    r.key_b       = {$urandom, $urandom};
    r.key_c       = KEY_C_W'($urandom);
    r.amount      = pick_amount();
    r.drain_first = drain;
    pending.push_back(r);
    queued_items++;
  endfunction

  task automatic present(input request_t r);
    live_request = r;
    in_req_type    <= r.kind;
    in_key_bytes_a <= r.key_a;
    in_key_bytes_b <= r.key_b;
    in_key_bytes_c <= r.key_c;
    in_amount      <= r.amount;
  endtask

  always @(posedge clk) begin : drive_requests
    int r;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      tally_request(live_request);
      r = $urandom_range(0, 99);
      if (calm_left > 0) begin
        calm_left--;
        gap_left = 0;
      end else if (r < 3) begin
        calm_left = $urandom_range(10, 40);
        gap_left  = 0;
      end else if (r < 50) begin
        gap_left = 0;
      end else if (r < 90) begin
        gap_left = $urandom_range(1, 4);
      end else begin
        gap_left = $urandom_range(10, 150);
      end
      // Keep start high into the next request when there is no gap.
      if (gap_left == 0 && pending.size() > 0 && !pending[0].drain_first) begin
        present(pending.pop_front());
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() > 0 &&
                   (!pending[0].drain_first || (sorted_rows_due.size() == 0 && !busy))) begin
        present(pending.pop_front());
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_rows
    row_t want;
    if (rst_n && out_valid) begin
      if (sorted_rows_due.size() == 0) begin
        log_mismatch($sformatf("unexpected row: key %h_%h_%h total %0d",
                               out_key_a, out_key_b, out_key_c, out_total));
      end else begin
        want = sorted_rows_due.pop_front();
        if (out_key_a !== want.key_a)
          log_mismatch($sformatf("out_key_a %h, want %h", out_key_a, want.key_a));
        if (out_key_b !== want.key_b)
          log_mismatch($sformatf("out_key_b %h, want %h", out_key_b, want.key_b));
        if (out_key_c !== want.key_c)
          log_mismatch($sformatf("out_key_c %h, want %h", out_key_c, want.key_c));
        if (out_total !== want.total)
          log_mismatch($sformatf("out_total %0d, want %0d", out_total, want.total));
        if (out_is_last !== want.is_last)
          log_mismatch($sformatf("out_is_last %b, want %b", out_is_last, want.is_last));
        if (out_overflowed !== want.overflowed)
          log_mismatch($sformatf("out_overflowed %b, want %b", out_overflowed, want.overflowed));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAIL group_sum_then_sort");
    $finish;
  end

  initial begin : stimulus
    logic [KEY_W-1:0] pool[64];
    logic [KEY_W-1:0] k;
    int               pool_n;
    int               adds;
    int               mode;
    int               target;
    bit               sweep;

    // Empty table, saturation both ways, junk after the terminator, ties.
    queue_flush(1'b0);
    queue_add('0, 0);
    queue_add('1, TOT_MAX);
    queue_add('1, 1);
    queue_add({8'h41, 8'h00, {17{8'hff}}}, TOT_MIN);
    queue_add({8'h41, 144'h0}, -1);
    queue_add({8'h42, 144'h0}, 5);
    queue_add({8'h43, 144'h0}, 5);
    queue_add({8'h00, {18{8'ha5}}}, 5);
    queue_flush(1'b1);
    queue_add(name_with_tail({8'h41, 144'h0}), TOT_MIN);
    queue_add({8'h41, 144'h0}, -5);
    queue_add('1, TOT_MIN);
    queue_add('1, TOT_MIN);
    queue_flush(1'b0);
    queue_flush(1'b0);

    target = queued_items + RANDOM_ITEMS;
    while (queued_items < target) begin
      mode  = $urandom_range(0, 99);
      sweep = 1'b0;
      if (mode < 15) begin
        // Overfill the table so later new names are dropped.
        pool_n = $urandom_range(CAPACITY + 1, CAPACITY + 8);
        adds   = pool_n + $urandom_range(5, 15);
        sweep  = 1'b1;
      end else if (mode < 25) begin
        pool_n = $urandom_range(20, CAPACITY);
        adds   = $urandom_range(pool_n, pool_n + 20);
      end else begin
        pool_n = $urandom_range(1, 8);
        adds   = $urandom_range(1, 20);
      end
      for (int i = 0; i < pool_n; i++) pool[i] = fresh_name();
      for (int i = 0; i < adds; i++) begin
        if (sweep && i < pool_n) k = pool[i];
        else k = pool[$urandom_range(0, pool_n - 1)];
        if ($urandom_range(0, 19) == 0) k = fresh_name();
        queue_add(name_with_tail(k), pick_amount());
      end
      queue_flush($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) queue_flush(1'b0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() > 0 || start || sorted_rows_due.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS group_sum_then_sort");
    else $display("FAIL group_sum_then_sort");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/gss_pkg.sv
hw/rtl/gss_canon.sv
hw/rtl/gss_store.sv
hw/rtl/gss_ctrl.sv
hw/rtl/group_sum_then_sort.sv
bench/tb.sv
